// ===== rtl/core/lab_pkg.sv =====
// Package for the look-at basis pipeline: widths, shared types and constants.
// Used by lab_norm, lab_xprod and look_at_basis; depends on nothing.

package lab_pkg;

  localparam int FIX_W       = 32;  // Q16.16 coordinates
  localparam int UNIT_W      = 18;  // Q1.16 unit components
  localparam int VEC_W       = 64;  // raw vector entering the normalizer
  localparam int MAG_W       = 31;  // magnitude after the normalizing shift
  localparam int SQ_W        = 62;  // square of one magnitude
  localparam int LEN_W       = 32;  // integer square root
  localparam int NUM_W       = 48;  // dividend of the unit division
  localparam int QUO_W       = 17;  // quotient before clamping
  localparam int PROD_W      = 50;  // cross product terms
  localparam int SHIFT_STEPS = 6;   // shift by 32, 16, 8, 4, 2, 1
  localparam int ISQ_STEPS   = 32;  // one root bit per stage
  localparam int DIV_STEPS   = 17;  // one quotient bit per stage
  localparam int FRAC_BITS   = 16;
  localparam int ONE_INT     = 65536;

  localparam logic [15:0] MIN_DIST_RST = 16'd7;

  typedef logic signed [FIX_W-1:0]  fix_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Sideband that rides along with an item through the arithmetic units
  typedef struct packed {
    logic  coin;                  // eye and target coincide or lie closer than min_distance
    fix_t  eye_x, eye_y, eye_z;
    fix_t  aux_x, aux_y, aux_z;   // up hint, later the side vector
    unit_t f_x, f_y, f_z;         // forward vector
  } tag_t;

  // One result item, first member in the highest bits
  typedef struct packed {
    logic [FIX_W-1:0]  place_z, place_y, place_x;
    logic [UNIT_W-1:0] back_z, back_y, back_x;
    logic [UNIT_W-1:0] up_z, up_y, up_x;
    logic [UNIT_W-1:0] right_z, right_y, right_x;
  } res_t;

endpackage

// ===== rtl/core/look_at_basis.sv =====
// Look-at camera basis: streaming top level with front stages, two normalizers,
// two cross products and the output register with skid stage.
// Depends on lab_pkg, lab_norm and lab_xprod.
//
// Usage:
//   Input requests on s_axis carry eye, target and up hint (Q16.16). Each
//   request yields exactly one result on m_axis: side vector, true up and
//   back vector in Q1.16 plus the eye translation, or the identity rotation
//   and zero translation when eye and target coincide or lie closer than min_distance.
//   cfg_we_i/cfg_wdata_i write min_distance; write it only while idle.
//   Throughput: one request per cycle while the skid register is empty. A
//   request passes the front stages, the two normalizers (60 stages each:
//   a 32-stage square root and a 17-stage divider), the two cross products
//   and the output stages before it reaches m_axis_tvalid.
//   When m_axis_tready is low the output register holds its result and the
//   skid register catches one more; the whole pipeline then freezes and
//   s_axis_tready drops until the skid register drains. Nothing is dropped
//   or repeated.
//   Reset clears all valid bits and sets min_distance to 7.

module look_at_basis (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, hint_up_x, hint_up_y, hint_up_z
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // right_x/y/z, true_up_x/y/z, back_x/y/z (18 b each), place_x/y/z (32 b each), 6 b zero
  output logic [263:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int FixW  = lab_pkg::FIX_W;
  localparam int UnitW = lab_pkg::UNIT_W;
  localparam int SqSum = 34;
  localparam lab_pkg::unit_t UnitOne = UnitW'(lab_pkg::ONE_INT);

  function automatic lab_pkg::fix_t sat_diff(lab_pkg::fix_t a, lab_pkg::fix_t b);
    logic signed [FixW:0] t;
    t = (FixW+1)'(a) - (FixW+1)'(b);
    if (t[FixW] != t[FixW-1]) begin
      return t[FixW] ? {1'b1, {(FixW-1){1'b0}}} : {1'b0, {(FixW-1){1'b1}}};
    end
    return t[FixW-1:0];
  endfunction

  function automatic lab_pkg::unit_t round_clamp(lab_pkg::prod_t c);
    lab_pkg::prod_t v;
    v = (c + lab_pkg::prod_t'(32768)) >>> lab_pkg::FRAC_BITS;
    if (v > lab_pkg::prod_t'(lab_pkg::ONE_INT)) begin
      return UnitOne;
    end
    if (v < -lab_pkg::prod_t'(lab_pkg::ONE_INT)) begin
      return -UnitOne;
    end
    return v[UnitW-1:0];
  endfunction

  // configuration
  logic [15:0] md_q;
  logic [31:0] md_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q    <= lab_pkg::MIN_DIST_RST;
      md_sq_q <= 32'(lab_pkg::MIN_DIST_RST) * 32'(lab_pkg::MIN_DIST_RST);
    end else begin
      if (cfg_we_i) md_q <= cfg_wdata_i;
      md_sq_q <= 32'(md_q) * 32'(md_q);
    end
  end

  // flow control: whole pipeline advances unless the skid register is full
  logic adv;
  logic skid_v_q, out_v_q;
  assign adv           = !skid_v_q;
  assign s_axis_tready = !skid_v_q;

  // front stages: difference, squares, coincidence
  logic          f1_v_q, f2_v_q, f3_v_q;
  lab_pkg::fix_t f1_d_q [3], f2_d_q [3], f3_d_q [3];
  lab_pkg::fix_t f1_eye_q [3], f2_eye_q [3], f3_eye_q [3];
  lab_pkg::fix_t f1_up_q [3], f2_up_q [3], f3_up_q [3];
  logic [31:0]   f2_sq_q [3];
  logic          f2_big_q, f2_zero_q, f3_coin_q;
  logic [31:0]   dm [3];
  logic [SqSum-1:0] sq_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) dm[i] = f1_d_q[i][FixW-1] ? -f1_d_q[i] : f1_d_q[i];
  end
  assign sq_sum = SqSum'(f2_sq_q[0]) + SqSum'(f2_sq_q[1]) + SqSum'(f2_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= s_axis_tvalid;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        f1_eye_q[i] <= s_axis_tdata[FixW*i +: FixW];
        f1_up_q[i]  <= s_axis_tdata[FixW*(6+i) +: FixW];
        f1_d_q[i]   <= sat_diff(s_axis_tdata[FixW*(3+i) +: FixW], s_axis_tdata[FixW*i +: FixW]);
        f2_d_q[i]   <= f1_d_q[i];
        f2_eye_q[i] <= f1_eye_q[i];
        f2_up_q[i]  <= f1_up_q[i];
        f2_sq_q[i]  <= 32'(dm[i][15:0]) * 32'(dm[i][15:0]);
        f3_d_q[i]   <= f2_d_q[i];
        f3_eye_q[i] <= f2_eye_q[i];
        f3_up_q[i]  <= f2_up_q[i];
      end
      // any magnitude of 2^16 or more puts the square sum above any threshold
      f2_big_q  <= (|dm[0][31:16]) | (|dm[1][31:16]) | (|dm[2][31:16]);
      f2_zero_q <= (dm[0] == '0) && (dm[1] == '0) && (dm[2] == '0);
      f3_coin_q <= f2_zero_q || (!f2_big_q && (sq_sum < SqSum'(md_sq_q)));
    end
  end

  // forward vector
  lab_pkg::vec_t  n1_vec [3];
  lab_pkg::tag_t  n1_tag_in, n1_tag;
  logic           n1_v;
  lab_pkg::unit_t fwd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) n1_vec[i] = lab_pkg::vec_t'(f3_d_q[i]);
    n1_tag_in       = '0;
    n1_tag_in.coin  = f3_coin_q;
    n1_tag_in.eye_x = f3_eye_q[0];
    n1_tag_in.eye_y = f3_eye_q[1];
    n1_tag_in.eye_z = f3_eye_q[2];
    n1_tag_in.aux_x = f3_up_q[0];
    n1_tag_in.aux_y = f3_up_q[1];
    n1_tag_in.aux_z = f3_up_q[2];
  end

  lab_norm u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f3_v_q),
    .vec_i   (n1_vec),
    .tag_i   (n1_tag_in),
    .valid_o (n1_v),
    .unit_o  (fwd),
    .tag_o   (n1_tag)
  );

  // forward x up
  lab_pkg::fix_t  x1_b [3];
  lab_pkg::tag_t  x1_tag_in, x1_tag;
  logic           x1_v;
  lab_pkg::prod_t x1_c [3];

  always_comb begin
    x1_b[0]         = n1_tag.aux_x;
    x1_b[1]         = n1_tag.aux_y;
    x1_b[2]         = n1_tag.aux_z;
    x1_tag_in       = n1_tag;
    x1_tag_in.aux_x = '0;
    x1_tag_in.aux_y = '0;
    x1_tag_in.aux_z = '0;
    x1_tag_in.f_x   = fwd[0];
    x1_tag_in.f_y   = fwd[1];
    x1_tag_in.f_z   = fwd[2];
  end

  lab_xprod u_xprod_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (n1_v),
    .a_i     (fwd),
    .b_i     (x1_b),
    .tag_i   (x1_tag_in),
    .valid_o (x1_v),
    .c_o     (x1_c),
    .tag_o   (x1_tag)
  );

  // side vector
  lab_pkg::vec_t  n2_vec [3];
  lab_pkg::tag_t  n2_tag;
  logic           n2_v;
  lab_pkg::unit_t side [3];

  always_comb begin
    for (int i = 0; i < 3; i++) n2_vec[i] = lab_pkg::vec_t'(x1_c[i]);
  end

  lab_norm u_norm_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (x1_v),
    .vec_i   (n2_vec),
    .tag_i   (x1_tag),
    .valid_o (n2_v),
    .unit_o  (side),
    .tag_o   (n2_tag)
  );

  // side x forward gives the true up; a zero side vector gives a zero up
  lab_pkg::fix_t  x2_b [3];
  lab_pkg::tag_t  x2_tag_in, x2_tag;
  logic           x2_v;
  lab_pkg::prod_t x2_c [3];

  always_comb begin
    x2_b[0]         = lab_pkg::fix_t'(n2_tag.f_x);
    x2_b[1]         = lab_pkg::fix_t'(n2_tag.f_y);
    x2_b[2]         = lab_pkg::fix_t'(n2_tag.f_z);
    x2_tag_in       = n2_tag;
    x2_tag_in.aux_x = lab_pkg::fix_t'(side[0]);
    x2_tag_in.aux_y = lab_pkg::fix_t'(side[1]);
    x2_tag_in.aux_z = lab_pkg::fix_t'(side[2]);
  end

  lab_xprod u_xprod_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (n2_v),
    .a_i     (side),
    .b_i     (x2_b),
    .tag_i   (x2_tag_in),
    .valid_o (x2_v),
    .c_o     (x2_c),
    .tag_o   (x2_tag)
  );

  // result assembly
  lab_pkg::res_t res_d, last_q, out_q, skid_q;
  logic          last_v_q;

  always_comb begin
    res_d = '0;
    if (x2_tag.coin) begin
      res_d.right_x = UnitOne;
      res_d.up_y    = UnitOne;
      res_d.back_z  = UnitOne;
    end else begin
      res_d.right_x = x2_tag.aux_x[UnitW-1:0];
      res_d.right_y = x2_tag.aux_y[UnitW-1:0];
      res_d.right_z = x2_tag.aux_z[UnitW-1:0];
      res_d.up_x    = round_clamp(x2_c[0]);
      res_d.up_y    = round_clamp(x2_c[1]);
      res_d.up_z    = round_clamp(x2_c[2]);
      res_d.back_x  = -x2_tag.f_x;
      res_d.back_y  = -x2_tag.f_y;
      res_d.back_z  = -x2_tag.f_z;
      res_d.place_x = x2_tag.eye_x;
      res_d.place_y = x2_tag.eye_y;
      res_d.place_z = x2_tag.eye_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) last_q <= res_d;
  end

  // output register plus skid register
  logic take;
  assign take = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) last_v_q <= x2_v;
      if (adv && last_v_q) begin
        if (!out_v_q || take) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (take) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_v_q) begin
      if (!out_v_q || take) begin
        out_q <= last_q;
      end else begin
        skid_q <= last_q;
      end
    end else if (take && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_q};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && m_axis_tready && skid_v_q) |=> (out_v_q && !skid_v_q))
    else $error("skid register did not move into the output register");

  a_up_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ($signed(out_q.up_x) <= 18'sd65536 && $signed(out_q.up_x) >= -18'sd65536))
    else $error("true up component outside the unit range");

endmodule

// ===== rtl/core/lab_xprod.sv =====
// Pipelined cross product a x b: products in one stage, differences in the next.
// Depends on lab_pkg.

module lab_xprod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  lab_pkg::unit_t  a_i [3],
  input  lab_pkg::fix_t   b_i [3],
  input  lab_pkg::tag_t   tag_i,
  output logic            valid_o,
  output lab_pkg::prod_t  c_o [3],
  output lab_pkg::tag_t   tag_o
);

  logic           v_q [2];
  lab_pkg::tag_t  tag_q [2];
  lab_pkg::prod_t p_q [6];
  lab_pkg::prod_t c_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
      v_q[1] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= valid_i;
      v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q[0] <= tag_i;
      tag_q[1] <= tag_q[0];
      p_q[0] <= lab_pkg::prod_t'(a_i[1]) * lab_pkg::prod_t'(b_i[2]);
      p_q[1] <= lab_pkg::prod_t'(a_i[2]) * lab_pkg::prod_t'(b_i[1]);
      p_q[2] <= lab_pkg::prod_t'(a_i[2]) * lab_pkg::prod_t'(b_i[0]);
      p_q[3] <= lab_pkg::prod_t'(a_i[0]) * lab_pkg::prod_t'(b_i[2]);
      p_q[4] <= lab_pkg::prod_t'(a_i[0]) * lab_pkg::prod_t'(b_i[1]);
      p_q[5] <= lab_pkg::prod_t'(a_i[1]) * lab_pkg::prod_t'(b_i[0]);
      c_q[0] <= p_q[0] - p_q[1];
      c_q[1] <= p_q[2] - p_q[3];
      c_q[2] <= p_q[4] - p_q[5];
    end
  end

  assign valid_o = v_q[1];
  assign c_o     = c_q;
  assign tag_o   = tag_q[1];

endmodule

// ===== rtl/core/lab_norm.sv =====
// Pipelined vector normalizer: magnitude, normalizing shift, sum of squares,
// bit-per-stage integer square root and bit-per-stage division to Q1.16.
// Depends on lab_pkg.

module lab_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  lab_pkg::vec_t   vec_i [3],
  input  lab_pkg::tag_t   tag_i,
  output logic            valid_o,
  output lab_pkg::unit_t  unit_o [3],
  output lab_pkg::tag_t   tag_o
);

  localparam int VecW  = lab_pkg::VEC_W;
  localparam int MagW  = lab_pkg::MAG_W;
  localparam int SqW   = lab_pkg::SQ_W;
  localparam int LenW  = lab_pkg::LEN_W;
  localparam int NumW  = lab_pkg::NUM_W;
  localparam int QuoW  = lab_pkg::QUO_W;
  localparam int UnitW = lab_pkg::UNIT_W;
  localparam int NSh   = lab_pkg::SHIFT_STEPS;
  localparam int NIsq  = lab_pkg::ISQ_STEPS;
  localparam int NDiv  = lab_pkg::DIV_STEPS;
  localparam int PSq   = NSh + 1;
  localparam int PSum  = PSq + 1;
  localparam int PNum  = PSum + NIsq + 1;
  localparam int POut  = PNum + NDiv + 1;
  localparam int NStg  = POut + 1;
  localparam logic [QuoW-1:0] QuoOne = QuoW'(lab_pkg::ONE_INT);

  typedef struct packed {
    logic [2:0]           neg;
    logic                 nz;
    logic [2:0][MagW-1:0] a;
    lab_pkg::tag_t        tag;
  } car_t;

  typedef struct packed {
    logic [VecW-1:0] s;
    logic [VecW-1:0] r;
  } isq_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [QuoW-1:0] quo;
  } dstep_t;

  function automatic logic [VecW-1:0] mag_of(lab_pkg::vec_t v);
    return v[VecW-1] ? -v : v;
  endfunction

  function automatic logic top_clear(logic [VecW-1:0] w, int amt);
    return (w >> (VecW - amt)) == '0;
  endfunction

  function automatic isq_t isq_step(isq_t x, int k);
    logic [VecW-1:0] bitv;
    logic [VecW-1:0] tr;
    isq_t            y;
    bitv = VecW'(1) << (2 * (NIsq - 1 - k));
    tr   = x.r + bitv;
    if (x.s >= tr) begin
      y.s = x.s - tr;
      y.r = (x.r >> 1) + bitv;
    end else begin
      y.s = x.s;
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  function automatic dstep_t div_step(dstep_t x, logic [LenW-1:0] len, int sh);
    logic [NumW-1:0] t;
    dstep_t          y;
    t = NumW'(len) << sh;
    y = x;
    if (x.rem >= t) begin
      y.rem = x.rem - t;
      y.quo = x.quo | (QuoW'(1) << sh);
    end
    return y;
  endfunction

  function automatic lab_pkg::unit_t to_unit(logic [QuoW-1:0] q, logic neg, logic nz);
    logic [QuoW-1:0] qc;
    lab_pkg::unit_t  m;
    qc = (q > QuoOne) ? QuoOne : q;
    m  = lab_pkg::unit_t'({1'b0, qc});
    if (!nz) begin
      return '0;
    end
    return neg ? -m : m;
  endfunction

  logic            v_q    [NStg];
  car_t            car_q  [NStg];
  logic [VecW-1:0] m_q    [NSh+1][3];
  logic [SqW-1:0]  sq_q   [3];
  isq_t            isq_q  [NIsq+1];
  dstep_t          dv_q   [NDiv+1][3];
  logic [LenW-1:0] len_q  [NDiv+1];
  lab_pkg::unit_t  unit_q [3];

  logic [VecW-1:0] w_fin;
  logic [LenW-1:0] root;

  assign w_fin = m_q[NSh][0] | m_q[NSh][1] | m_q[NSh][2];
  assign root  = isq_q[NIsq].r[LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NStg; k++) v_q[k] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < NStg; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      car_q[0].neg <= {vec_i[2][VecW-1], vec_i[1][VecW-1], vec_i[0][VecW-1]};
      car_q[0].nz  <= 1'b0;
      car_q[0].a   <= '0;
      car_q[0].tag <= tag_i;
      for (int k = 1; k < NStg; k++) begin
        if (k != PSq) car_q[k] <= car_q[k-1];
      end
      // msb of the largest magnitude now sits at the top bit
      car_q[PSq].neg <= car_q[PSq-1].neg;
      car_q[PSq].tag <= car_q[PSq-1].tag;
      car_q[PSq].nz  <= w_fin[VecW-1];
      car_q[PSq].a   <= {m_q[NSh][2][VecW-1 -: MagW], m_q[NSh][1][VecW-1 -: MagW],
                         m_q[NSh][0][VecW-1 -: MagW]};

      for (int i = 0; i < 3; i++) m_q[0][i] <= mag_of(vec_i[i]);
      for (int s = 0; s < NSh; s++) begin
        for (int i = 0; i < 3; i++) begin
          m_q[s+1][i] <= top_clear(m_q[s][0] | m_q[s][1] | m_q[s][2], 32 >> s)
                         ? (m_q[s][i] << (32 >> s)) : m_q[s][i];
        end
      end

      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SqW'(m_q[NSh][i][VecW-1 -: MagW]) * SqW'(m_q[NSh][i][VecW-1 -: MagW]);
      end

      isq_q[0].s <= VecW'(sq_q[0]) + VecW'(sq_q[1]) + VecW'(sq_q[2]);
      isq_q[0].r <= '0;
      for (int k = 0; k < NIsq; k++) isq_q[k+1] <= isq_step(isq_q[k], k);

      // dividend m * 2^16 + floor(len / 2) for round to nearest
      len_q[0] <= root;
      for (int i = 0; i < 3; i++) begin
        dv_q[0][i].rem <= NumW'({car_q[PNum-1].a[i], {lab_pkg::FRAC_BITS{1'b0}}})
                          + NumW'(root >> 1);
        dv_q[0][i].quo <= '0;
      end
      for (int j = 0; j < NDiv; j++) begin
        len_q[j+1] <= len_q[j];
        for (int i = 0; i < 3; i++) begin
          dv_q[j+1][i] <= div_step(dv_q[j][i], len_q[j], NDiv - 1 - j);
        end
      end

      for (int i = 0; i < 3; i++) begin
        unit_q[i] <= to_unit(dv_q[NDiv][i].quo, car_q[POut-1].neg[i], car_q[POut-1].nz);
      end
    end
  end

  assign valid_o = v_q[POut];
  assign unit_o  = unit_q;
  assign tag_o   = car_q[POut].tag;

endmodule

// ===== tb/lab_checker.sv =====
// Checker for look_at_basis: watches the request, result and register ports,
// predicts each camera basis and compares it field by field. Needs lab_pkg only.
`timescale 1ns / 1ps

module lab_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [263:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  output int           pending_o,
  output int           fails_o
);

  logic [263:0] basis_q[$];
  logic [15:0]  min_dist;
  int           n_seen;

  assign pending_o = basis_q.size();

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_one(longint v);
    if (v > lab_pkg::ONE_INT) return lab_pkg::ONE_INT;
    if (v < -lab_pkg::ONE_INT) return -lab_pkg::ONE_INT;
    return v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale to Q1.16 unit length; false for a zero vector
  function automatic bit unitize(input longint cx, cy, cz,
                                 output longint nx, ny, nz);
    longint      c[3], n[3];
    logic [63:0] m[3], mx, len, q;
    c[0] = cx; c[1] = cy; c[2] = cz;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    nx = 0; ny = 0; nz = 0;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 16) + (len >> 1)) / len;
      if (q > lab_pkg::ONE_INT) q = lab_pkg::ONE_INT;
      n[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
    nx = n[0]; ny = n[1]; nz = n[2];
    return 1;
  endfunction

  function automatic logic [263:0] basis_of(logic [287:0] req, logic [15:0] md);
    longint      eye[3], d[3], up[3], f[3], cr[3], s[3], u[3], r[12];
    logic [63:0] sq, mg, md64;
    logic [263:0] o;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      eye[i] = $signed(req[32*i +: 32]);
      up[i]  = $signed(req[192 + 32*i +: 32]);
      d[i]   = clip32(longint'($signed(req[96 + 32*i +: 32])) - eye[i]);
      mg     = (d[i] < 0) ? -d[i] : d[i];
      sq     = sq + mg * mg;
    end
    md64 = {48'd0, md};
    for (int i = 0; i < 12; i++) r[i] = 0;
    if (sq == 0 || sq < md64 * md64) begin
      r[0] = lab_pkg::ONE_INT; r[4] = lab_pkg::ONE_INT; r[8] = lab_pkg::ONE_INT;
    end else begin
      void'(unitize(d[0], d[1], d[2], f[0], f[1], f[2]));
      cr[0] = f[1] * up[2] - f[2] * up[1];
      cr[1] = f[2] * up[0] - f[0] * up[2];
      cr[2] = f[0] * up[1] - f[1] * up[0];
      if (unitize(cr[0], cr[1], cr[2], s[0], s[1], s[2])) begin
        // floor shift after adding half
        u[0] = clip_one((s[1] * f[2] - s[2] * f[1] + 32768) >>> 16);
        u[1] = clip_one((s[2] * f[0] - s[0] * f[2] + 32768) >>> 16);
        u[2] = clip_one((s[0] * f[1] - s[1] * f[0] + 32768) >>> 16);
      end else begin
        u[0] = 0; u[1] = 0; u[2] = 0;
      end
      for (int i = 0; i < 3; i++) begin
        r[i] = s[i]; r[3+i] = u[i]; r[6+i] = -f[i]; r[9+i] = eye[i];
      end
    end
    o = '0;
    for (int i = 0; i < 9; i++) o[18*i +: 18] = r[i][17:0];
    for (int i = 0; i < 3; i++) o[162 + 32*i +: 32] = r[9+i][31:0];
    return o;
  endfunction

  task automatic report(string what, int idx, longint got, longint want);
    $display("mismatch result %0d %s: got %0d expected %0d", idx, what, got, want);
    fails_o++;
  endtask

  string fname[12] = '{"right_x", "right_y", "right_z", "true_up_x", "true_up_y",
                       "true_up_z", "back_x", "back_y", "back_z", "place_x",
                       "place_y", "place_z"};

  initial fails_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic [263:0] want;
    if (!rst_ni) begin
      min_dist = lab_pkg::MIN_DIST_RST;
      n_seen   = 0;
    end else begin
      if (cfg_we_i) min_dist = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) basis_q.push_back(basis_of(s_axis_tdata, min_dist));
      if (m_axis_tvalid && m_axis_tready) begin
        if (basis_q.size() == 0) begin
          $display("unexpected result %0d", n_seen);
          fails_o++;
        end else begin
          want = basis_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_axis_tdata[18*i +: 18] !== want[18*i +: 18])
              report(fname[i], n_seen, $signed(m_axis_tdata[18*i +: 18]),
                     $signed(want[18*i +: 18]));
          for (int i = 0; i < 3; i++)
            if (m_axis_tdata[162 + 32*i +: 32] !== want[162 + 32*i +: 32])
              report(fname[9+i], n_seen, $signed(m_axis_tdata[162 + 32*i +: 32]),
                     $signed(want[162 + 32*i +: 32]));
        end
        n_seen++;
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the look_at_basis testbench: clock, reset, request and stall stimulus,
// register writes and the verdict. Depends on lab_pkg, look_at_basis, lab_checker.
`timescale 1ns / 1ps

module tb;
  localparam int DRAIN = 150;
  localparam int QUIET_LIMIT = 4000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [263:0] m_axis_tdata;
  logic         cfg_we_i = 0;
  logic [15:0]  cfg_wdata_i = '0;
  int           pending, fails;
  int           burst_left = 0;
  int           quiet = 0;
  bit           hold_go = 0;
  bit           choppy = 1;

  always #5 clk_i = ~clk_i;

  look_at_basis DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i
  );

  lab_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i,
    .pending_o(pending), .fails_o(fails)
  );

  // Result side: random stalls, free stretches, and a long hold-off on demand
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go && hold == 0) hold = 400;
      if (hold > 0) begin
        hold--;
        if (hold == 0) hold_go = 0;
        m_axis_tready <= 1'b0;
      end else if (choppy) begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) choppy = !choppy;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive one request, keep tvalid up within a burst
  task automatic send_req(logic [287:0] req);
    s_axis_tdata  <= req;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (burst_left <= 0) burst_left = $urandom_range(1, 12);
    burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 15) : 0) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic write_min_dist(logic [15:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] coord(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic logic [287:0] pack(logic [31:0] e[3], logic [31:0] t[3],
                                        logic [31:0] u[3]);
    logic [287:0] p;
    for (int i = 0; i < 3; i++) begin
      p[32*i +: 32]       = e[i];
      p[96 + 32*i +: 32]  = t[i];
      p[192 + 32*i +: 32] = u[i];
    end
    return p;
  endfunction

  // Random request: wide, mid, tiny-offset and extreme points; up hints that
  // are random, parallel to the view direction, or zero
  function automatic logic [287:0] rand_req();
    logic [31:0] e[3], t[3], u[3];
    int kind, near, upk, k;
    kind = $urandom_range(0, 9);
    kind = (kind < 4) ? 0 : (kind < 8) ? 1 : (kind < 9) ? 3 : 0;
    near = $urandom_range(0, 3);
    upk  = $urandom_range(0, 9);
    k    = $signed($urandom_range(0, 6)) - 3;
    for (int i = 0; i < 3; i++) begin
      e[i] = coord(kind);
      t[i] = (near == 0) ? e[i] + coord(2) : coord(kind);
      u[i] = (upk < 7) ? coord($urandom_range(0, 3)) : 32'd0;
    end
    if (upk == 8)
      for (int i = 0; i < 3; i++) u[i] = (t[i] - e[i]) * k;
    return pack(e, t, u);
  endfunction

  task automatic rand_phase(int n);
    for (int i = 0; i < n; i++) send_req(rand_req());
  endtask

  logic [31:0] ze[3], zt[3], zu[3];
  localparam logic [31:0] MAXC = 32'h7fffffff;
  localparam logic [31:0] MINC = 32'h80000000;
  localparam logic [31:0] ONE = 32'h00010000;

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed requests under the reset threshold
    ze = '{0, 0, 0}; zt = '{0, 0, 0}; zu = '{0, ONE, 0};
    send_req(pack(ze, zt, zu));                               // same point
    zt = '{3, 2, 1};        send_req(pack(ze, zt, zu));       // inside threshold
    zt = '{7, 0, 0};        send_req(pack(ze, zt, zu));       // on threshold
    zt = '{0, 0, -ONE};     send_req(pack(ze, zt, zu));
    zt = '{ONE, 0, 0};      send_req(pack(ze, zt, zu));
    zt = '{0, ONE, 0};      send_req(pack(ze, zt, zu));       // up along forward
    zt = '{0, -5 * ONE, 0}; send_req(pack(ze, zt, zu));       // up against forward
    zu = '{0, 0, 0}; zt = '{ONE, ONE, ONE};
    send_req(pack(ze, zt, zu));                               // zero up hint
    ze = '{MINC, MINC, MINC}; zt = '{MAXC, MAXC, MAXC}; zu = '{MAXC, MINC, MAXC};
    send_req(pack(ze, zt, zu));                               // saturating difference
    ze = '{MAXC, MAXC, MAXC}; zt = '{MINC, MINC, MINC}; zu = '{MINC, MAXC, MINC};
    send_req(pack(ze, zt, zu));
    ze = '{MAXC, 0, MINC}; zt = '{MINC, 0, MAXC}; zu = '{MAXC, MAXC, MAXC};
    send_req(pack(ze, zt, zu));
    ze = '{MINC, MAXC, 0}; zt = '{MINC, MINC, 1}; zu = '{MINC, MINC, MINC};
    send_req(pack(ze, zt, zu));
    ze = '{-1, -1, -1}; zt = '{1, 1, 1}; zu = '{1, -1, 1};
    send_req(pack(ze, zt, zu));
    ze = '{5, 6, 7}; zt = '{5, 6, 7}; zu = '{MAXC, MAXC, MAXC};
    send_req(pack(ze, zt, zu));
    ze = '{0, 0, 0}; zt = '{1, 0, 1}; zu = '{0, 1, 0};
    send_req(pack(ze, zt, zu));                               // tiny distance
    rand_phase(150);

    // Sender pauses until the pipeline is empty, then the result side holds
    // off long enough that the pipeline fills and stalls the request side
    wait_idle();
    hold_go = 1;
    rand_phase(300 / 2);

    write_min_dist(16'd0);
    ze = '{9, 9, 9}; zt = '{9, 9, 9}; zu = '{0, ONE, 0};
    send_req(pack(ze, zt, zu));                               // zero offset, no threshold
    zt = '{9, 9, 10}; send_req(pack(ze, zt, zu));
    rand_phase(80);

    write_min_dist(16'hffff);
    rand_phase(80);

    write_min_dist(16'($urandom()));
    rand_phase(60);

    wait_idle();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
